/* design/skrt_pkg.sv */
// Shared types, codes and helpers for the sorted keyed record table.
`default_nettype none

package skrt_pkg;

   localparam int CAPACITY_DEF   = 32;
   localparam int NAME_CHARS_DEF = 24;

   // request codes
   localparam logic [2:0] REQ_INSERT = 3'd0;
   localparam logic [2:0] REQ_SEARCH = 3'd1;
   localparam logic [2:0] REQ_UPDATE = 3'd2;
   localparam logic [2:0] REQ_ERASE  = 3'd3;
   localparam logic [2:0] REQ_LIST   = 3'd4;

   // result status codes
   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_NOT_FOUND = 3'd1;
   localparam logic [2:0] STAT_DUPLICATE = 3'd2;
   localparam logic [2:0] STAT_FULL      = 3'd3;
   localparam logic [2:0] STAT_EMPTY     = 3'd4;

   // read address select
   localparam logic [1:0] RD_IDX   = 2'd0;
   localparam logic [1:0] RD_BELOW = 2'd1;
   localparam logic [1:0] RD_ABOVE = 2'd2;

   // write select
   localparam logic [1:0] WR_SHIFT = 2'd0;
   localparam logic [1:0] WR_NEW   = 2'd1;
   localparam logic [1:0] WR_UPD   = 2'd2;

   // result source select
   localparam logic [2:0] EMIT_REC   = 3'd0;
   localparam logic [2:0] EMIT_NEW   = 3'd1;
   localparam logic [2:0] EMIT_UPD   = 3'd2;
   localparam logic [2:0] EMIT_ERR   = 3'd3;
   localparam logic [2:0] EMIT_EMPTY = 3'd4;

   localparam logic signed [31:0] QTY_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] QTY_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [2:0]         req_type;
      logic signed [31:0] part_key;
      logic [63:0]        name_word0;
      logic [63:0]        name_word1;
      logic [63:0]        name_word2;
      logic signed [31:0] amount;
   } req_beat_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] out_key;
      logic [63:0]        out_name0;
      logic [63:0]        out_name1;
      logic [63:0]        out_name2;
      logic signed [31:0] quantity;
      logic               last_result;
   } rsp_beat_type;

   typedef struct packed {
      logic signed [31:0] key;
      logic [63:0]        name0;
      logic [63:0]        name1;
      logic [63:0]        name2;
      logic signed [31:0] qty;
   } rec_type;

   typedef struct packed {
      logic       latch_req;
      logic       idx_clear;
      logic       idx_inc;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       walk_load_count;
      logic       walk_load_idx;
      logic       walk_dec;
      logic       walk_inc;
      logic       wr_en;
      logic [1:0] wr_sel;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       emit;
      logic [2:0] emit_src;
      logic [2:0] emit_status;
      logic       emit_last;
   } cmd_type;

   typedef struct packed {
      logic [2:0] req_code;
      logic       count_zero;
      logic       count_full;
      logic       idx_at_end;
      logic       idx_at_last;
      logic       key_below;
      logic       key_match;
      logic       walk_above_idx;
      logic       walk_up_more;
   } stat_type;

   // keep mask for one 8-byte name word
   function automatic logic [63:0] name_mask(input int word, input int chars);
      int keep;
      keep = chars - 8 * word;
      if (keep >= 8) begin
         return {64{1'b1}};
      end else if (keep <= 0) begin
         return 64'd0;
      end else begin
         return {64{1'b1}} >> (64 - 8 * keep);
      end
   endfunction

endpackage

`default_nettype wire

/* design/skrt_ctrl.sv */
// Controller state machine for the sorted keyed record table.
`default_nettype none

module skrt_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire skrt_pkg::stat_type stat,
   output skrt_pkg::cmd_type      cmd
);
   import skrt_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECODE   = 4'd1;
   localparam logic [3:0] S_SCAN_RD  = 4'd2;
   localparam logic [3:0] S_SCAN_CHK = 4'd3;
   localparam logic [3:0] S_INS_RD   = 4'd4;
   localparam logic [3:0] S_INS_WR   = 4'd5;
   localparam logic [3:0] S_ERS_RD   = 4'd6;
   localparam logic [3:0] S_ERS_WR   = 4'd7;
   localparam logic [3:0] S_LIST_RD  = 4'd8;
   localparam logic [3:0] S_LIST_OUT = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       resolve, found;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      resolve  = 1'b0;
      found    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch_req = 1'b1;
               cmd.idx_clear = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.req_code) inside
               REQ_INSERT: begin
                  if (stat.count_full) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_src    = EMIT_ERR;
                     cmd.emit_status = STAT_FULL;
                     cmd.emit_last   = 1'b1;
                     state_in        = S_IDLE;
                  end else begin
                     state_in = S_SCAN_RD;
                  end
               end
               REQ_SEARCH, REQ_UPDATE, REQ_ERASE: state_in = S_SCAN_RD;
               REQ_LIST: begin
                  if (stat.count_zero) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_src    = EMIT_EMPTY;
                     cmd.emit_status = STAT_EMPTY;
                     cmd.emit_last   = 1'b1;
                     state_in        = S_IDLE;
                  end else begin
                     state_in = S_LIST_RD;
                  end
               end
               default: state_in = S_IDLE;   // unused codes: dropped
            endcase
         end
         S_SCAN_RD: begin
            if (stat.idx_at_end) begin
               resolve = 1'b1;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_IDX;
               state_in   = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (stat.key_below) begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SCAN_RD;
            end else begin
               resolve = 1'b1;
               found   = stat.key_match;
            end
         end
         S_INS_RD: begin
            if (stat.walk_above_idx) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_BELOW;
               state_in   = S_INS_WR;
            end else begin
               cmd.wr_en     = 1'b1;
               cmd.wr_sel    = WR_NEW;
               cmd.cnt_inc   = 1'b1;
               cmd.emit      = 1'b1;
               cmd.emit_src  = EMIT_NEW;
               cmd.emit_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_INS_WR: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_sel   = WR_SHIFT;
            cmd.walk_dec = 1'b1;
            state_in     = S_INS_RD;
         end
         S_ERS_RD: begin
            if (stat.walk_up_more) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_ABOVE;
               state_in   = S_ERS_WR;
            end else begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_ERS_WR: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_sel   = WR_SHIFT;
            cmd.walk_inc = 1'b1;
            state_in     = S_ERS_RD;
         end
         S_LIST_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_IDX;
            state_in   = S_LIST_OUT;
         end
         S_LIST_OUT: begin
            cmd.emit      = 1'b1;
            cmd.emit_src  = EMIT_REC;
            cmd.emit_last = stat.idx_at_last;
            if (stat.idx_at_last) begin
               state_in = S_IDLE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_LIST_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // lookup finished: idx holds the lower-bound position
      if (resolve) begin
         cmd.emit_last = 1'b1;
         state_in      = S_IDLE;
         if (stat.req_code == REQ_INSERT) begin
            if (found) begin
               cmd.emit        = 1'b1;
               cmd.emit_src    = EMIT_ERR;
               cmd.emit_status = STAT_DUPLICATE;
            end else begin
               cmd.walk_load_count = 1'b1;
               state_in            = S_INS_RD;
            end
         end else if (!found) begin
            cmd.emit        = 1'b1;
            cmd.emit_src    = EMIT_ERR;
            cmd.emit_status = STAT_NOT_FOUND;
         end else begin
            cmd.emit = 1'b1;
            unique case (stat.req_code)
               REQ_UPDATE: begin
                  cmd.wr_en    = 1'b1;
                  cmd.wr_sel   = WR_UPD;
                  cmd.emit_src = EMIT_UPD;
               end
               REQ_ERASE: begin
                  cmd.emit_src      = EMIT_REC;
                  cmd.walk_load_idx = 1'b1;
                  state_in          = S_ERS_RD;
               end
               default: cmd.emit_src = EMIT_REC;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* design/skrt_dpath.sv */
// Datapath: record memory, counters, compare, saturating add, result register.
`default_nettype none

module skrt_dpath #(
   parameter int CAPACITY   = skrt_pkg::CAPACITY_DEF,
   parameter int NAME_CHARS = skrt_pkg::NAME_CHARS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire skrt_pkg::req_beat_type req_data,
   input  wire skrt_pkg::cmd_type     cmd,
   output skrt_pkg::stat_type         stat,
   output logic                       rsp_valid,
   output skrt_pkg::rsp_beat_type     rsp_data
);
   import skrt_pkg::*;

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam logic [63:0] MASK0 = name_mask(0, NAME_CHARS);
   localparam logic [63:0] MASK1 = name_mask(1, NAME_CHARS);
   localparam logic [63:0] MASK2 = name_mask(2, NAME_CHARS);

   rec_type rec_mem [CAPACITY];
   rec_type rd_data_ff;

   req_beat_type req_ff, req_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] walk_ff, walk_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_beat_type     rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]  walk_dn, walk_up;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   rec_type           wr_rec, new_rec, upd_rec;
   logic signed [32:0] qty_sum;
   logic signed [31:0] qty_sat;

   assign walk_dn = walk_ff - CNT_W'(1);
   assign walk_up = walk_ff + CNT_W'(1);

   // status toward the controller
   assign stat.req_code       = req_ff.req_type;
   assign stat.count_zero     = (count_ff == '0);
   assign stat.count_full     = (count_ff == CNT_W'(CAPACITY));
   assign stat.idx_at_end     = (idx_ff == count_ff);
   assign stat.idx_at_last    = (({1'b0, idx_ff} + (CNT_W + 1)'(1)) == {1'b0, count_ff});
   assign stat.key_below      = ($signed(rd_data_ff.key) < $signed(req_ff.part_key));
   assign stat.key_match      = (rd_data_ff.key == req_ff.part_key);
   assign stat.walk_above_idx = (walk_ff > idx_ff);
   assign stat.walk_up_more   = (({1'b0, walk_ff} + (CNT_W + 1)'(1)) < {1'b0, count_ff});

   // new record, name trimmed to NAME_CHARS bytes
   assign new_rec.key   = req_ff.part_key;
   assign new_rec.name0 = req_ff.name_word0 & MASK0;
   assign new_rec.name1 = req_ff.name_word1 & MASK1;
   assign new_rec.name2 = req_ff.name_word2 & MASK2;
   assign new_rec.qty   = req_ff.amount;

   // saturating quantity update
   assign qty_sum = {rd_data_ff.qty[31], rd_data_ff.qty} + {req_ff.amount[31], req_ff.amount};
   always_comb begin
      if (qty_sum[32] != qty_sum[31]) begin
         qty_sat = qty_sum[32] ? QTY_MIN : QTY_MAX;
      end else begin
         qty_sat = qty_sum[31:0];
      end
   end

   always_comb begin
      upd_rec     = rd_data_ff;
      upd_rec.qty = qty_sat;
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_BELOW: rd_addr = walk_dn[ADDR_W-1:0];
         RD_ABOVE: rd_addr = walk_up[ADDR_W-1:0];
         default:  rd_addr = idx_ff[ADDR_W-1:0];
      endcase
   end

   always_comb begin
      case (cmd.wr_sel)
         WR_NEW: begin
            wr_addr = idx_ff[ADDR_W-1:0];
            wr_rec  = new_rec;
         end
         WR_UPD: begin
            wr_addr = idx_ff[ADDR_W-1:0];
            wr_rec  = upd_rec;
         end
         default: begin
            wr_addr = walk_ff[ADDR_W-1:0];
            wr_rec  = rd_data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         rec_mem[wr_addr] <= wr_rec;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= rec_mem[rd_addr];
      end
   end

   // counters and request register
   always_comb begin
      req_in   = cmd.latch_req ? req_data : req_ff;
      idx_in   = idx_ff;
      walk_in  = walk_ff;
      count_in = count_ff;
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + CNT_W'(1);
      end
      if (cmd.walk_load_count) begin
         walk_in = count_ff;
      end else if (cmd.walk_load_idx) begin
         walk_in = idx_ff;
      end else if (cmd.walk_dec) begin
         walk_in = walk_dn;
      end else if (cmd.walk_inc) begin
         walk_in = walk_up;
      end
      if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // result beat
   always_comb begin
      rsp_valid_in            = cmd.emit;
      rsp_data_in.status      = STAT_OK;
      rsp_data_in.out_key     = rd_data_ff.key;
      rsp_data_in.out_name0   = rd_data_ff.name0;
      rsp_data_in.out_name1   = rd_data_ff.name1;
      rsp_data_in.out_name2   = rd_data_ff.name2;
      rsp_data_in.quantity    = rd_data_ff.qty;
      rsp_data_in.last_result = cmd.emit_last;
      case (cmd.emit_src)
         EMIT_NEW: begin
            rsp_data_in.out_key   = new_rec.key;
            rsp_data_in.out_name0 = new_rec.name0;
            rsp_data_in.out_name1 = new_rec.name1;
            rsp_data_in.out_name2 = new_rec.name2;
            rsp_data_in.quantity  = new_rec.qty;
         end
         EMIT_UPD: rsp_data_in.quantity = qty_sat;
         EMIT_ERR, EMIT_EMPTY: begin
            rsp_data_in.status    = cmd.emit_status;
            rsp_data_in.out_key   = (cmd.emit_src == EMIT_ERR) ? req_ff.part_key : 32'sd0;
            rsp_data_in.out_name0 = '0;
            rsp_data_in.out_name1 = '0;
            rsp_data_in.out_name2 = '0;
            rsp_data_in.quantity  = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         walk_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* design/sorted_keyed_record_table.sv */
// Top level of the sorted keyed record table: controller plus datapath.
`default_nettype none

// Sorted keyed record table: up to CAPACITY records (key, name, quantity)
// held in ascending signed key order in a single-port-write record memory.
// Request channel: a beat on req_data is taken at a clock edge where start
//   is high and busy is low. Codes 5 to 7 are taken and dropped silently.
// Result channel: each result beat sits on rsp_data for one cycle, marked
//   by rsp_valid; last_result flags the final beat of a request. There is
//   no backpressure, so the receiver must take every beat as it comes.
// Timing: a decode state, then the lookup compares entries in order, each
//   as a memory read and then a compare, and stops at the first entry whose
//   key is not below the request key or at the end of the table. Insert then
//   moves each later entry up (read, then write) and stores the new record;
//   erase moves each later entry down the same way. A list reads and emits
//   one beat per record. Each beat appears the cycle after the state that
//   produces it. The next request beat is taken once busy drops.
// Reset: synchronous; clears the entry count, counters, state and strobe.
//   The record memory is not cleared: only entries below the count are read.

module sorted_keyed_record_table #(
   parameter int CAPACITY   = skrt_pkg::CAPACITY_DEF,
   parameter int NAME_CHARS = skrt_pkg::NAME_CHARS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire skrt_pkg::req_beat_type req_data,
   output logic                        rsp_valid,
   output skrt_pkg::rsp_beat_type      rsp_data
);
   import skrt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   skrt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   skrt_dpath #(
      .CAPACITY   (CAPACITY),
      .NAME_CHARS (NAME_CHARS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // memory is only written while a request is in flight
   a_wr_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> busy)
      else $error("record write while idle");

   // a full table never grows
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      stat.count_full |-> !cmd.cnt_inc)
      else $error("entry count past capacity");

   // the idle cycle never produces a beat, so none shows right after accept
   a_no_beat_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid)
      else $error("result beat right after accept");

   a_cnt_one_way: assert property (@(posedge clock) disable iff (reset)
      !(cmd.cnt_inc && cmd.cnt_dec))
      else $error("entry count moved both ways");

endmodule

`default_nettype wire
